/* src/noi_pkg.sv */
// Shared constants, codes and interface structs for the niche occurrence unit.
// No dependencies; imported by every module of the block.
package noi_pkg;

  localparam int MAX_SPECIES = 64;
  localparam int IDX_W       = $clog2(MAX_SPECIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int WADDR_W     = 2 * IDX_W;
  // |diff * p| < 2^32, summed over MAX_SPECIES rows, plus sign
  localparam int SCORE_W     = 33 + IDX_W;
  localparam int MAG_W       = SCORE_W - 1;

  localparam int DIV_R_W     = 48;   // remainder / divisor width
  localparam int DIV_L_W     = 32;   // dividend bits shifted in, quotient width
  localparam int DIV_S_W     = 6;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  // e^-1 in Q30 from the 12-term truncated series
  localparam logic [31:0] E1_Q30  = 32'd395007543;

  localparam logic [1:0] CMD_LOAD_TRAIT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] CMD_EVAL        = 2'd2;

  localparam logic [1:0] CFG_SPECIES_COUNT = 2'd0;
  localparam logic [1:0] CFG_STRENGTH      = 2'd1;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic signed [15:0] opt;
    logic [15:0]        width;
    logic [16:0]        peak;
  } trait_wr_t;

  typedef struct packed {
    logic signed [15:0] opt;
    logic [15:0]        width;
    logic [16:0]        peak;
  } trait_rd_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic signed [15:0] data;
  } weight_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [16:0]      data;
  } prob_wr_t;

  typedef struct packed {
    logic               start;
    logic [DIV_R_W-1:0] rem_init;
    logic [DIV_L_W-1:0] low;
    logic [DIV_S_W-1:0] steps;
    logic [DIV_R_W-1:0] divisor;
  } div_req_t;

endpackage

/* src/noi_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on noi_pkg for widths and the request struct.
module noi_div (
  input  logic              clk,
  input  logic              rst,
  input  noi_pkg::div_req_t req,
  output logic              done,
  output logic [noi_pkg::DIV_L_W-1:0] quot
);
  import noi_pkg::*;

  logic [DIV_R_W-1:0] rem;
  logic [DIV_R_W-1:0] divisor;
  logic [DIV_L_W-1:0] low;
  logic [DIV_S_W-1:0] cnt;
  logic               running;
  logic [DIV_R_W:0]   trial;
  logic               ge;

  assign trial = {rem, low[DIV_L_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= req.rem_init;
        low     <= req.low;
        divisor <= req.divisor;
        cnt     <= req.steps;
        quot    <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem  <= ge ? DIV_R_W'(trial - {1'b0, divisor}) : trial[DIV_R_W-1:0];
        low  <= {low[DIV_L_W-2:0], 1'b0};
        quot <= {quot[DIV_L_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == DIV_S_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/noi_trait.sv */
// Species trait store: optimum, niche width and peak, one entry per species.
// Depends on noi_pkg; width and peak read as 1.0 until first written.
module noi_trait (
  input  logic                      clk,
  input  logic                      rst,
  input  noi_pkg::trait_wr_t        wr,
  input  logic [noi_pkg::IDX_W-1:0] raddr,
  output noi_pkg::trait_rd_t        rd
);
  import noi_pkg::*;

  logic signed [15:0] opt_mem   [MAX_SPECIES];
  logic [15:0]        width_mem [MAX_SPECIES];
  logic [16:0]        peak_mem  [MAX_SPECIES];
  logic [MAX_SPECIES-1:0] vld;

  logic signed [15:0] opt_q;
  logic [15:0]        width_q;
  logic [16:0]        peak_q;
  logic               vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      opt_mem[wr.addr]   <= wr.opt;
      width_mem[wr.addr] <= wr.width;
      peak_mem[wr.addr]  <= wr.peak;
    end
    opt_q   <= opt_mem[raddr];
    width_q <= width_mem[raddr];
    peak_q  <= peak_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) vld[wr.addr] <= 1'b1;
      vld_q <= vld[raddr];
    end
  end

  assign rd.opt   = opt_q;
  assign rd.width = vld_q ? width_q : 16'd256;
  assign rd.peak  = vld_q ? peak_q : ONE_Q16;

endmodule

/* src/noi_score.sv */
// Interaction score engine: weight matrix and base probability memories
// with a three-stage multiply-accumulate. Depends on noi_pkg.
module noi_score (
  input  logic                      clk,
  input  logic                      rst,
  input  noi_pkg::weight_wr_t       ww,
  input  noi_pkg::prob_wr_t         pw,
  input  logic                      start,
  input  logic [noi_pkg::IDX_W-1:0] row,
  input  logic [noi_pkg::CNT_W-1:0] count,
  output logic                      done,
  output logic signed [noi_pkg::SCORE_W-1:0] score,
  output logic [16:0]               p_row
);
  import noi_pkg::*;

  logic signed [15:0] w_mem [MAX_SPECIES * MAX_SPECIES];
  logic [16:0]        p_mem [MAX_SPECIES];

  logic [CNT_W-1:0]   k;
  logic               issuing;
  logic               v1, v1_last, v1_row;
  logic               v2, v2_last;
  logic signed [15:0] wa_q, wb_q;
  logic [16:0]        p_q;
  logic signed [16:0] diff;
  logic signed [34:0] prod;

  // row-major weight address {row, col}
  always_ff @(posedge clk) begin
    if (ww.en) w_mem[ww.addr] <= ww.data;
    if (pw.en) p_mem[pw.addr] <= pw.data;
    wa_q <= w_mem[{row, k[IDX_W-1:0]}];
    wb_q <= w_mem[{k[IDX_W-1:0], row}];
    p_q  <= p_mem[k[IDX_W-1:0]];
  end

  assign diff = {wa_q[15], wa_q} - {wb_q[15], wb_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= issuing;
      v2   <= v1;
      if (start) begin
        k       <= '0;
        issuing <= 1'b1;
        score   <= '0;
      end else if (issuing) begin
        k       <= k + 1'b1;
        v1_last <= CNT_W'(k + 1'b1) == count;
        v1_row  <= k[IDX_W-1:0] == row;
        if (CNT_W'(k + 1'b1) == count) issuing <= 1'b0;
      end
      if (v1) begin
        prod    <= diff * $signed({1'b0, p_q});
        v2_last <= v1_last;
        if (v1_row) p_row <= p_q;
      end
      if (v2) begin
        score <= score + SCORE_W'(prod);
        if (v2_last) done <= 1'b1;
      end
    end
  end

endmodule

/* src/niche_interaction_occurrence_unit.sv */
// Top level: command decode, configuration registers and the evaluation sequencer.
// Depends on noi_pkg, noi_div, noi_trait and noi_score.
//
// Load commands (traits, one weight, or a rejected index/command) give one
// result in the cycle after they are accepted. An evaluation of n species runs
// two passes: base probabilities, then interaction scores and the logistic
// mix. Per species, the base pass runs a serial divide of the squared
// distance by the width, the 12-term exponential series (one multiply and
// one reciprocal multiply per term), and one multiply by e^-1 per integer
// unit ip (0..31) of the exponent; series and integer steps are skipped when
// the exponent saturates. The score pass per species runs the weight matrix
// walk, the same exponential, and a serial divide for the final ratio.
// Results come with valid high for one cycle each and cannot be held off;
// busy is high throughout an evaluation.
module niche_interaction_occurrence_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [5:0]  species_index,
  input  logic [5:0]  partner_index,
  input  logic signed [15:0] niche_optimum,
  input  logic [15:0] niche_width,
  input  logic [16:0] peak_probability,
  input  logic signed [15:0] interaction_weight,
  input  logic signed [15:0] env_value,
  output logic        valid,
  output logic [5:0]  out_species,
  output logic [16:0] probability,
  output logic        status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import noi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_A_RD, S_A_SQ, S_A_DIV, S_A_DIVW, S_A_PK,
    S_B_START, S_B_WAIT, S_B_M1, S_B_M2, S_B_QMUL, S_B_QDIV, S_B_QW,
    S_EX_INIT, S_EX_MUL, S_EX_DIV, S_EX_INT, S_EX_IMUL, S_EX_RET
  } state_t;

  state_t state;

  logic [CNT_W-1:0] species_count;
  logic [15:0]      alpha;
  logic [CNT_W-1:0] n;

  logic             accept;
  logic             idx_bad, pidx_bad;
  trait_wr_t        tw;
  weight_wr_t       ww;
  prob_wr_t         pw;
  trait_rd_t        tr;
  div_req_t         dreq;
  logic             div_done;
  logic [DIV_L_W-1:0] div_quot;
  logic             sc_done;
  logic signed [SCORE_W-1:0] sc_score;
  logic [16:0]      sc_prow;

  logic [IDX_W-1:0] j;
  logic signed [15:0] env;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic [15:0]      wid;
  logic [16:0]      pk;
  logic [31:0]      ex_y;
  logic [4:0]       ex_ip;
  logic [3:0]       ex_n;
  logic signed [31:0] ex_acc;
  logic [30:0]      ex_r;
  logic [31:0]      ex_recip;
  logic [5:0]       ex_k;
  logic [31:0]      ex_quot;
  logic             ret_final;
  logic [MAG_W-1:0] mag;
  logic             sneg;
  logic [16:0]      pj;
  logic [47:0]      lo;
  logic [45:0]      num;
  logic [47:0]      den;

  logic signed [16:0] d;
  logic [16:0]      dabs;
  logic [MAG_W-1:0] sc_mag;
  logic [53:0]      smag;
  logic [16:0]      one_minus_p;
  logic             j_last;

  assign cfg_ready = 1'b1;
  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;

  assign n = (species_count == '0) ? CNT_W'(1) :
             (species_count > CNT_W'(MAX_SPECIES)) ? CNT_W'(MAX_SPECIES) : species_count;

  assign idx_bad  = {1'b0, species_index} >= n;
  assign pidx_bad = {1'b0, partner_index} >= n;
  assign j_last   = CNT_W'(j + 1'b1) == n;

  always_ff @(posedge clk) begin
    if (rst) begin
      species_count <= CNT_W'(1);
      alpha         <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPECIES_COUNT: species_count <= cfg_data[CNT_W-1:0];
        CFG_STRENGTH:      alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  // load writes; width zero and peak above one are clamped on the way in
  always_comb begin
    tw.en    = accept && cmd == CMD_LOAD_TRAIT && !idx_bad;
    tw.addr  = species_index;
    tw.opt   = niche_optimum;
    tw.width = (niche_width == '0) ? 16'd1 : niche_width;
    tw.peak  = (peak_probability > ONE_Q16) ? ONE_Q16 : peak_probability;
    ww.en    = accept && cmd == CMD_LOAD_WEIGHT && !idx_bad && !pidx_bad;
    ww.addr  = {species_index, partner_index};
    ww.data  = interaction_weight;
    pw.en    = state == S_A_PK;
    pw.addr  = j;
    pw.data  = prod[46:30];
  end

  assign prod        = mul_a * mul_b;
  assign d           = {env[15], env} - {tr.opt[15], tr.opt};
  assign dabs        = d[16] ? -d : d;
  assign sc_mag      = sc_score[SCORE_W-1] ? MAG_W'(-sc_score) : sc_score[MAG_W-1:0];
  assign smag        = {6'b0, lo} + {prod[21:0], 32'b0};
  assign one_minus_p = ONE_Q16 - pj;

  // series term divide by n (1..12): v * ceil(2^k / n) >> k, k = 31 + clog2(n),
  // exact for v below 2^31
  always_comb begin
    case (ex_n)
      4'd1:  begin ex_recip = 32'd2147483648; ex_k = 6'd31; end
      4'd2:  begin ex_recip = 32'd2147483648; ex_k = 6'd32; end
      4'd3:  begin ex_recip = 32'd2863311531; ex_k = 6'd33; end
      4'd4:  begin ex_recip = 32'd2147483648; ex_k = 6'd33; end
      4'd5:  begin ex_recip = 32'd3435973837; ex_k = 6'd34; end
      4'd6:  begin ex_recip = 32'd2863311531; ex_k = 6'd34; end
      4'd7:  begin ex_recip = 32'd2454267027; ex_k = 6'd34; end
      4'd8:  begin ex_recip = 32'd2147483648; ex_k = 6'd34; end
      4'd9:  begin ex_recip = 32'd3817748708; ex_k = 6'd35; end
      4'd10: begin ex_recip = 32'd3435973837; ex_k = 6'd35; end
      4'd11: begin ex_recip = 32'd3123612579; ex_k = 6'd35; end
      4'd12: begin ex_recip = 32'd2863311531; ex_k = 6'd35; end
      default: begin ex_recip = 32'd2147483648; ex_k = 6'd31; end
    endcase
  end

  assign ex_quot = 32'(prod >> ex_k);

  always_comb begin
    dreq = '0;
    case (state)
      S_A_DIV: begin
        dreq.start   = 1'b1;
        dreq.low     = prod[31:0];
        dreq.steps   = DIV_S_W'(32);
        dreq.divisor = {32'b0, wid};
      end
      S_B_QDIV: begin
        // quotient stays within 17 bits, so the top of (num << 16) seeds the remainder
        dreq.start    = 1'b1;
        dreq.rem_init = {3'b0, num[45:1]};
        dreq.low      = {num[0], 31'b0};
        dreq.steps    = DIV_S_W'(17);
        dreq.divisor  = den;
      end
      default: ;
    endcase
  end

  noi_trait u_trait (
    .clk   (clk),
    .rst   (rst),
    .wr    (tw),
    .raddr (j),
    .rd    (tr)
  );

  noi_score u_score (
    .clk   (clk),
    .rst   (rst),
    .ww    (ww),
    .pw    (pw),
    .start (state == S_B_START),
    .row   (j),
    .count (n),
    .done  (sc_done),
    .score (sc_score),
    .p_row (sc_prow)
  );

  noi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_species <= species_index;
            probability <= '0;
            last        <= 1'b1;
            case (cmd)
              CMD_LOAD_TRAIT: begin
                valid  <= 1'b1;
                status <= idx_bad;
              end
              CMD_LOAD_WEIGHT: begin
                valid  <= 1'b1;
                status <= idx_bad || pidx_bad;
              end
              CMD_EVAL: begin
                env   <= env_value;
                j     <= '0;
                state <= S_A_RD;
              end
              default: begin
                valid  <= 1'b1;
                status <= 1'b1;
              end
            endcase
          end
        end
        S_A_RD: state <= S_A_SQ;
        S_A_SQ: begin
          mul_a <= {16'b0, dabs[15:0]};
          mul_b <= {16'b0, dabs[15:0]};
          wid   <= tr.width;
          pk    <= tr.peak;
          state <= S_A_DIV;
        end
        S_A_DIV: state <= S_A_DIVW;
        S_A_DIVW: begin
          if (div_done) begin
            ex_y      <= div_quot;
            ret_final <= 1'b0;
            state     <= S_EX_INIT;
          end
        end
        S_A_PK: begin
          if (j_last) begin
            j     <= '0;
            state <= S_B_START;
          end else begin
            j     <= j + 1'b1;
            state <= S_A_RD;
          end
        end
        S_B_START: state <= S_B_WAIT;
        S_B_WAIT: begin
          if (sc_done) begin
            mag   <= sc_mag;
            sneg  <= sc_score[SCORE_W-1] && alpha != '0;
            pj    <= sc_prow;
            mul_a <= {16'b0, alpha};
            mul_b <= sc_mag[31:0];
            state <= S_B_M1;
          end
        end
        S_B_M1: begin
          lo    <= prod[47:0];
          mul_b <= 32'(mag[MAG_W-1:32]);
          state <= S_B_M2;
        end
        S_B_M2: begin
          ex_y      <= 32'(smag[53:28]);
          ret_final <= 1'b1;
          state     <= S_EX_INIT;
        end
        S_B_QMUL: begin
          if (!sneg) begin
            num <= prod[45:0];
            den <= {2'b0, prod[45:0]} + {2'b0, one_minus_p[15:0], 30'b0};
          end else begin
            num <= {pj[15:0], 30'b0};
            den <= {2'b0, pj[15:0], 30'b0} + {2'b0, prod[45:0]};
          end
          state <= S_B_QDIV;
        end
        S_B_QDIV: state <= S_B_QW;
        S_B_QW: begin
          if (div_done) begin
            valid       <= 1'b1;
            out_species <= j;
            probability <= div_quot[16:0];
            status      <= 1'b0;
            last        <= j_last;
            j           <= j + 1'b1;
            state       <= j_last ? S_IDLE : S_B_START;
          end
        end
        // exponential e^-y, y in Q24.8: series on the fraction, then e^-1 per unit
        S_EX_INIT: begin
          if (ex_y[31:13] != '0) begin
            ex_r  <= '0;
            state <= S_EX_RET;
          end else begin
            ex_acc <= ONE_Q30;
            ex_n   <= 4'd1;
            ex_ip  <= ex_y[12:8];
            mul_a  <= ONE_Q30;
            mul_b  <= {2'b0, ex_y[7:0], 22'b0};
            state  <= S_EX_MUL;
          end
        end
        S_EX_MUL: begin
          mul_a <= {1'b0, prod[60:30]};
          mul_b <= ex_recip;
          state <= S_EX_DIV;
        end
        S_EX_DIV: begin
          ex_acc <= ex_n[0] ? ex_acc - $signed(ex_quot) : ex_acc + $signed(ex_quot);
          mul_a  <= ex_quot;
          mul_b  <= {2'b0, ex_y[7:0], 22'b0};
          if (ex_n == 4'd12) begin
            state <= S_EX_INT;
          end else begin
            ex_n  <= ex_n + 1'b1;
            state <= S_EX_MUL;
          end
        end
        S_EX_INT: begin
          if (ex_ip == '0) begin
            ex_r  <= ex_acc[31] ? '0 : ex_acc[30:0];
            state <= S_EX_RET;
          end else begin
            mul_a <= ex_acc[31] ? '0 : {1'b0, ex_acc[30:0]};
            mul_b <= E1_Q30;
            state <= S_EX_IMUL;
          end
        end
        S_EX_IMUL: begin
          if (ex_ip == 5'd1) begin
            ex_r  <= prod[60:30];
            state <= S_EX_RET;
          end else begin
            ex_ip <= ex_ip - 1'b1;
            mul_a <= {1'b0, prod[60:30]};
          end
        end
        S_EX_RET: begin
          if (!ret_final) begin
            mul_a <= {15'b0, pk};
            mul_b <= {1'b0, ex_r};
            state <= S_A_PK;
          end else if (pj == '0 || pj[16]) begin
            // p of zero or one passes through unchanged
            valid       <= 1'b1;
            out_species <= j;
            probability <= pj;
            status      <= 1'b0;
            last        <= j_last;
            j           <= j + 1'b1;
            state       <= j_last ? S_IDLE : S_B_START;
          end else begin
            mul_a <= sneg ? {15'b0, one_minus_p} : {15'b0, pj};
            mul_b <= {1'b0, ex_r};
            state <= S_B_QMUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_eval_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_EVAL |=> busy)
    else $error("evaluate did not start");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("non-final result outside an evaluation");

  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    valid && status |-> last && probability == '0)
    else $error("rejected transfer must be a single zero result");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> probability <= ONE_Q16)
    else $error("probability above one");
`endif

endmodule
